[sv/fmac_pkg.sv]
//------------------------------------------------------------------------------
// fmac_pkg: shared types, constants and functions
// Holds the AES round functions, the command record passed from the front end
// to the back end, and the block-level constants.
//------------------------------------------------------------------------------
package fmac_pkg;

  localparam logic [7:0] MAX_FRAME_BYTES = 8'd255;
  localparam logic [7:0] HDR_TAG         = 8'h49;
  localparam logic [7:0] PAD_BYTE        = 8'h80;
  localparam logic [7:0] DBL_POLY        = 8'h87;
  localparam int         QUEUE_DEPTH     = 4;
  localparam int         QPTR_W          = 2;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  // Block kinds handed to the back end.
  typedef enum logic [1:0] {
    BLK_HEADER   = 2'd0,
    BLK_MIDDLE   = 2'd1,
    BLK_LAST     = 2'd2,
    BLK_HDR_ONLY = 2'd3
  } blk_kind_t;

  typedef struct packed {
    blk_kind_t    kind;
    logic         subkey_k2;
    logic [127:0] data;
  } blk_cmd_t;

  typedef enum logic [1:0] {
    BE_IDLE  = 2'd0,
    BE_SUBK  = 2'd1,
    BE_RUN   = 2'd2
  } be_state_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits in bits 127-8*i downto 120-8*i.
  function automatic logic [7:0] get_b(input logic [127:0] v, input int i);
    return v[127-8*i -: 8];
  endfunction

  // One AES round on state s; last drops the column mix.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[r+4*c] = sbox(get_b(s, r + 4*((c + r) % 4)));
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = t[i];
    end
    return o ^ rk;
  endfunction

  // Next round key from the previous one.
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    tw = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] gf_dbl(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? {120'd0, DBL_POLY} : 128'd0);
  endfunction

endpackage

[sv/frame_mic_aes_cmac.sv]
//------------------------------------------------------------------------------
// frame_mic_aes_cmac: frame MIC engine on AES-128 CMAC
// Input channel: one payload byte per item; the first item of a frame also
// carries length, device address, direction and frame counter. Result
// channel: one 32-bit MIC after the last byte of each frame (or after the
// first item of a zero-length frame). Items without an open frame give none.
// Configuration: cfg_we writes key_high (index 0) or key_low (index 1).
// A front end packs bytes into 16-byte blocks and queues them; a back end
// runs each block through an AES core of one round per cycle, plus an extra
// pass at each frame start to derive the subkeys. Bytes are taken one per
// cycle while the queue has two free slots. Long frames sustain one byte per
// cycle while the receiver keeps up; short frames are bound by the back end's
// subkey pass and block passes. With the back end idle the MIC appears once
// the last block has been through the core (for a zero-length frame, once the
// subkey pass and the header block are done); blocks still queued ahead of
// the last one add their own time. A stalled receiver holds the MIC register,
// and the back end waits before finishing the next frame. Reset empties the
// queue, clears the key, subkeys and chaining value, and closes any frame.
//------------------------------------------------------------------------------
module frame_mic_aes_cmac (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_frame,
  input  logic [7:0]  in_frame_length,
  input  logic [31:0] in_device_address,
  input  logic        in_direction,
  input  logic [31:0] in_frame_counter,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_mic
);
  import fmac_pkg::*;

  logic     q_valid, q_pop;
  blk_cmd_t q_head;

  fmac_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_first_of_frame (in_first_of_frame),
    .in_frame_length   (in_frame_length),
    .in_device_address (in_device_address),
    .in_direction      (in_direction),
    .in_frame_counter  (in_frame_counter),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_head            (q_head)
  );

  fmac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_mic   (out_mic)
  );
endmodule

[sv/fmac_aes_core.sv]
//------------------------------------------------------------------------------
// fmac_aes_core: iterative AES-128 encryption
// One round per cycle with on-the-fly key expansion; start is ignored while busy.
//------------------------------------------------------------------------------
module fmac_aes_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [127:0] blk,
  output logic         busy,
  output logic         done,
  output logic [127:0] result
);
  import fmac_pkg::*;

  logic [127:0] st_r, st_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [127:0] rk_step;

  assign rk_step = key_step(rk_r, rcon_r);

  always_comb begin
    st_nxt   = st_r;
    rk_nxt   = rk_r;
    rcon_nxt = rcon_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      st_nxt   = aes_round(st_r, rk_step, rnd_r == 4'd10);
      rk_nxt   = rk_step;
      rcon_nxt = xt(rcon_r);
      rnd_nxt  = rnd_r + 4'd1;
      if (rnd_r == 4'd10) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      st_nxt   = blk ^ key;
      rk_nxt   = key;
      rcon_nxt = 8'h01;
      rnd_nxt  = 4'd1;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    rk_r   <= rk_nxt;
    rcon_r <= rcon_nxt;
    rnd_r  <= rnd_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = st_r;
endmodule

[sv/fmac_front.sv]
//------------------------------------------------------------------------------
// fmac_front: frame parser and block gatherer
// Accepts items, builds the header block, packs payload bytes into blocks and
// queues each finished block with its kind for the back end.
//------------------------------------------------------------------------------
module fmac_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first_of_frame,
  input  logic [7:0]          in_frame_length,
  input  logic [31:0]         in_device_address,
  input  logic                in_direction,
  input  logic [31:0]         in_frame_counter,
  output logic                q_valid,
  input  logic                q_pop,
  output fmac_pkg::blk_cmd_t  q_head
);
  import fmac_pkg::*;

  blk_cmd_t          q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic [127:0]      buf_r, buf_nxt;
  logic [4:0]        fill_r, fill_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic              act_r, act_nxt;
  logic              acc;
  logic              push, push2;
  blk_cmd_t          cmd_a, cmd_b;
  logic [127:0]      hdr, pbuf, padded;
  logic [3:0]        pidx;
  logic [7:0]        len;
  logic [4:0]        pfill;
  logic [7:0]        prem;

  // Two free slots are kept so that a header and a final block can go in at once.
  assign in_ready = (cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
  assign acc      = in_valid && in_ready;
  assign len      = in_frame_length;

  always_comb begin
    hdr = 128'd0;
    hdr[127:120] = HDR_TAG;
    hdr[127-40 -: 8] = {7'd0, in_direction};
    for (int i = 0; i < 4; i++) begin
      hdr[127-8*(6+i) -: 8]  = in_device_address[8*i +: 8];
      hdr[127-8*(10+i) -: 8] = in_frame_counter[8*i +: 8];
    end
    hdr[7:0] = len;
  end

  always_comb begin
    buf_nxt  = buf_r;
    fill_nxt = fill_r;
    rem_nxt  = rem_r;
    act_nxt  = act_r;
    push     = 1'b0;
    push2    = 1'b0;
    cmd_a    = '{kind: BLK_MIDDLE, subkey_k2: 1'b0, data: 128'd0};
    cmd_b    = cmd_a;
    pbuf     = buf_r;
    pfill    = fill_r;
    prem     = rem_r;
    padded   = 128'd0;
    pidx     = 4'd0;
    if (acc) begin
      if (in_first_of_frame) begin
        if (len == 8'd0) begin
          push  = 1'b1;
          cmd_a = '{kind: BLK_HDR_ONLY, subkey_k2: 1'b0, data: hdr};
          act_nxt = 1'b0;
          rem_nxt = 8'd0;
          fill_nxt = 5'd0;
        end else begin
          push  = 1'b1;
          cmd_a = '{kind: BLK_HEADER, subkey_k2: 1'b0, data: hdr};
          pbuf  = 128'd0;
          pfill = 5'd0;
          prem  = len;
        end
      end
      if ((in_first_of_frame && len != 8'd0) || (!in_first_of_frame && act_r)) begin
        pidx = pfill[3:0];
        pbuf[127-8*pidx -: 8] = in_data_byte;
        pfill = pfill + 5'd1;
        prem  = prem - 8'd1;
        if (prem == 8'd0) begin
          padded = pbuf;
          if (pfill != 5'd16) begin
            padded[127-8*pfill[3:0] -: 8] = PAD_BYTE;
          end
          cmd_b = '{kind: BLK_LAST, subkey_k2: pfill != 5'd16, data: padded};
          act_nxt  = 1'b0;
          fill_nxt = 5'd0;
          rem_nxt  = 8'd0;
          buf_nxt  = 128'd0;
        end else if (pfill == 5'd16) begin
          cmd_b    = '{kind: BLK_MIDDLE, subkey_k2: 1'b0, data: pbuf};
          act_nxt  = 1'b1;
          fill_nxt = 5'd0;
          rem_nxt  = prem;
          buf_nxt  = 128'd0;
        end else begin
          act_nxt  = 1'b1;
          fill_nxt = pfill;
          rem_nxt  = prem;
          buf_nxt  = pbuf;
        end
        if (prem == 8'd0 || pfill == 5'd16) begin
          if (push) begin
            push2 = 1'b1;
          end else begin
            push  = 1'b1;
            cmd_a = cmd_b;
          end
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) + (QPTR_W+1)'(push2) - (QPTR_W+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (push) begin
      q_mem_r[wp_r] <= cmd_a;
    end
    if (push2) begin
      q_mem_r[wp_r + QPTR_W'(1)] <= cmd_b;
    end
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      fill_r <= 5'd0;
      rem_r  <= 8'd0;
      act_r  <= 1'b0;
    end else begin
      wp_r   <= wp_r + QPTR_W'(push) + QPTR_W'(push2);
      rp_r   <= rp_r + QPTR_W'(q_pop);
      cnt_r  <= cnt_nxt;
      fill_r <= fill_nxt;
      rem_r  <= rem_nxt;
      act_r  <= act_nxt;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_head  = q_mem_r[rp_r];
endmodule

[sv/fmac_back.sv]
//------------------------------------------------------------------------------
// fmac_back: CMAC chaining engine
// Takes queued blocks, derives subkeys at each header, chains the blocks
// through the AES core and holds the MIC in an output register.
//------------------------------------------------------------------------------
module fmac_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_wdata,
  input  logic               q_valid,
  output logic               q_pop,
  input  fmac_pkg::blk_cmd_t q_head,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_mic
);
  import fmac_pkg::*;

  be_state_t    st_r, st_nxt;
  blk_cmd_t     cur_r, cur_nxt;
  logic [127:0] key_r;
  logic [127:0] k1_r, k1_nxt, k2_r, k2_nxt;
  logic [127:0] cv_r, cv_nxt;
  logic         ov_r, ov_nxt;
  logic [31:0]  mic_r, mic_nxt;
  logic         a_start, a_busy, a_done;
  logic [127:0] a_blk, a_res, l1, sk;
  logic         head_ends, head_subk;

  fmac_aes_core u_aes (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (a_start),
    .key    (key_r),
    .blk    (a_blk),
    .busy   (a_busy),
    .done   (a_done),
    .result (a_res)
  );

  assign l1        = gf_dbl(a_res);
  assign sk        = q_head.kind == BLK_LAST ? (q_head.subkey_k2 ? k2_r : k1_r) : 128'd0;
  assign head_ends = q_head.kind == BLK_LAST || q_head.kind == BLK_HDR_ONLY;
  assign head_subk = q_head.kind == BLK_HEADER || q_head.kind == BLK_HDR_ONLY;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BE_IDLE: begin
        if (q_valid && !a_busy && !(head_ends && ov_r && !out_ready)) begin
          st_nxt = head_subk ? BE_SUBK : BE_RUN;
        end
      end
      BE_SUBK: begin
        if (a_done) st_nxt = BE_RUN;
      end
      BE_RUN: begin
        if (a_done) st_nxt = BE_IDLE;
      end
      default: st_nxt = BE_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    a_start = 1'b0;
    a_blk   = 128'd0;
    cur_nxt = cur_r;
    k1_nxt  = k1_r;
    k2_nxt  = k2_r;
    cv_nxt  = cv_r;
    ov_nxt  = ov_r && !out_ready;
    mic_nxt = mic_r;
    unique case (st_r)
      BE_IDLE: begin
        if (st_nxt != BE_IDLE) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          a_start = 1'b1;
          if (!head_subk) begin
            a_blk = q_head.data ^ cv_r ^ sk;
          end
        end
      end
      BE_SUBK: begin
        if (a_done) begin
          k1_nxt  = l1;
          k2_nxt  = gf_dbl(l1);
          cv_nxt  = 128'd0;
          a_start = 1'b1;
          // A header alone is the last block, complete, under K1.
          a_blk   = cur_r.data ^ (cur_r.kind == BLK_HDR_ONLY ? l1 : 128'd0);
        end
      end
      BE_RUN: begin
        if (a_done) begin
          cv_nxt = a_res;
          if (cur_r.kind == BLK_LAST || cur_r.kind == BLK_HDR_ONLY) begin
            ov_nxt = 1'b1;
            for (int i = 0; i < 4; i++) begin
              mic_nxt[8*i +: 8] = a_res[127-8*i -: 8];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    k1_r  <= k1_nxt;
    k2_r  <= k2_nxt;
    mic_r <= mic_nxt;
    if (cfg_we) begin
      if (cfg_index == CFG_KEY_HIGH) key_r[127:64] <= cfg_wdata;
      else key_r[63:0] <= cfg_wdata;
    end
    if (!rst_n) begin
      st_r  <= BE_IDLE;
      cv_r  <= 128'd0;
      ov_r  <= 1'b0;
      key_r <= 128'd0;
      k1_r  <= 128'd0;
      k2_r  <= 128'd0;
    end else begin
      st_r <= st_nxt;
      cv_r <= cv_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_mic   = mic_r;
endmodule
